### hw/rtl/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and register codes for the 3x3 RGB blur.
// ----------------------------------------------------------------------------
package gb3_pkg;

  typedef struct packed {
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  blur0;
    logic [7:0]  blur1;
    logic [7:0]  blur2;
    logic [10:0] out_col;
    logic [11:0] out_row;
    logic        frame_last;
  } out_word_t;

  // one line store entry: two rows above, one row above
  typedef struct packed {
    in_word_t above2;
    in_word_t above1;
  } line_pair_t;

  // window column: top, middle, bottom
  typedef struct packed {
    in_word_t top;
    in_word_t mid;
    in_word_t bot;
  } win_col_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [12:0] DIM_MIN      = 13'd3;
  localparam logic [11:0] WIDTH_RST    = 12'd640;
  localparam logic [12:0] HEIGHT_RST   = 13'd480;

endpackage

### hw/rtl/gb3_line_mem.sv
// ----------------------------------------------------------------------------
// gb3_line_mem
// Line store: both rows above in one synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module gb3_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output gb3_pkg::line_pair_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  gb3_pkg::line_pair_t wr_data
);

  gb3_pkg::line_pair_t mem [DEPTH];
  gb3_pkg::line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/gb3_window.sv
// ----------------------------------------------------------------------------
// gb3_window
// Two-column 3x3 window registers and the 1-2-1 kernel per channel.
// ----------------------------------------------------------------------------
module gb3_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  gb3_pkg::win_col_t new_col,
  output logic [7:0]        blur0,
  output logic [7:0]        blur1,
  output logic [7:0]        blur2
);

  gb3_pkg::win_col_t col0_r;
  gb3_pkg::win_col_t col1_r;

  function automatic logic [7:0] kern(
    input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2,
    input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
    input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
    logic [7:0] s;
    s = (a0 >> 4) + (a1 >> 3) + (a2 >> 4)
      + (b0 >> 3) + (b1 >> 2) + (b2 >> 3)
      + (c0 >> 4) + (c1 >> 3) + (c2 >> 4);
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col0_r <= '0;
      col1_r <= '0;
    end else if (step) begin
      col0_r <= col1_r;
      col1_r <= new_col;
    end
  end

  assign blur0 = kern(col0_r.top.chan0, col0_r.mid.chan0, col0_r.bot.chan0,
                      col1_r.top.chan0, col1_r.mid.chan0, col1_r.bot.chan0,
                      new_col.top.chan0, new_col.mid.chan0, new_col.bot.chan0);
  assign blur1 = kern(col0_r.top.chan1, col0_r.mid.chan1, col0_r.bot.chan1,
                      col1_r.top.chan1, col1_r.mid.chan1, col1_r.bot.chan1,
                      new_col.top.chan1, new_col.mid.chan1, new_col.bot.chan1);
  assign blur2 = kern(col0_r.top.chan2, col0_r.mid.chan2, col0_r.bot.chan2,
                      col1_r.top.chan2, col1_r.mid.chan2, col1_r.bot.chan2,
                      new_col.top.chan2, new_col.mid.chan2, new_col.bot.chan2);

endmodule

### hw/rtl/gaussian_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb
// Streaming 3x3 1-2-1 blur on RGB pixels with two line stores in one RAM.
// Pipeline: an accepted pixel is registered in stage 1, then its result in the output register.
// Throughput: 1 pixel/cycle unless in_stall; line RAM read at accept, written back as stage 1 drains.
// Reset: counters, window and valids clear; width 640, height 480; line RAM undefined.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gb3_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gb3_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > 12) ? WW : 12;
  localparam logic [CMPW-1:0] WMAX = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0] WMIN = CMPW'(3);

  // config
  logic [11:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= gb3_pkg::WIDTH_RST;
      frame_height_r <= gb3_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (gb3_pkg::reg_idx_t'(paddr[2]))
        gb3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[11:0];
        gb3_pkg::REG_FRAME_HEIGHT: frame_height_r <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (gb3_pkg::reg_idx_t'(paddr[2]))
      gb3_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, frame_width_r};
      gb3_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_r};
      default:                   prdata = '0;
    endcase
  end

  // effective frame size
  logic [CMPW-1:0] w_in, w_eff;
  logic [12:0]     h_eff;

  assign w_in  = CMPW'(frame_width_r);
  assign w_eff = (w_in < WMIN) ? WMIN : ((w_in > WMAX) ? WMAX : w_in);
  assign h_eff = (frame_height_r < gb3_pkg::DIM_MIN) ? gb3_pkg::DIM_MIN :
                 ((frame_height_r > gb3_pkg::HEIGHT_LIMIT) ? gb3_pkg::HEIGHT_LIMIT :
                  frame_height_r);

  // handshake
  logic in_acc, out_free, s1_adv;
  logic s1_valid_r;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // position counters
  logic [CW-1:0]   col_r, col_nxt;
  logic [11:0]     row_r, row_nxt;
  logic [CMPW-1:0] c_ext, c_inc;
  logic [12:0]     r_ext, r_inc;
  logic [CW-1:0]   c_cur;
  logic [11:0]     r_cur;

  assign c_ext = (CMPW'(col_r) >= w_eff) ? '0 : CMPW'(col_r);
  assign r_ext = ({1'b0, row_r} >= h_eff) ? '0 : {1'b0, row_r};
  assign c_cur = c_ext[CW-1:0];
  assign r_cur = r_ext[11:0];
  assign c_inc = c_ext + CMPW'(1);
  assign r_inc = r_ext + 13'd1;

  always_comb begin
    col_nxt = c_inc[CW-1:0];
    row_nxt = r_cur;
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? 12'd0 : r_inc[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line RAM data arrives
  gb3_pkg::in_word_t s1_pix_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_emit_r, s1_last_r;
  logic [10:0]       s1_ocol_r;
  logic [11:0]       s1_orow_r;
  logic [CMPW-1:0]   c_m1;
  logic [12:0]       r_m1;

  assign c_m1 = c_ext - CMPW'(1);
  assign r_m1 = r_ext - 13'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_data;
      s1_col_r  <= c_cur;
      s1_emit_r <= (c_ext >= CMPW'(2)) && (r_ext >= 13'd2);
      s1_last_r <= (c_inc == w_eff) && (r_inc == h_eff);
      s1_ocol_r <= c_m1[10:0];
      s1_orow_r <= r_m1[11:0];
    end
  end

  gb3_pkg::line_pair_t rd_line, wr_line;
  gb3_pkg::win_col_t   new_col;
  logic [7:0]          blur0, blur1, blur2;

  assign wr_line.above2 = rd_line.above1;
  assign wr_line.above1 = s1_pix_r;
  assign new_col.top    = rd_line.above2;
  assign new_col.mid    = rd_line.above1;
  assign new_col.bot    = s1_pix_r;

  gb3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (c_cur),
    .rd_data (rd_line),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (wr_line)
  );

  gb3_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .new_col (new_col),
    .blur0   (blur0),
    .blur1   (blur1),
    .blur2   (blur2)
  );

  // output register
  logic               out_valid_r;
  gb3_pkg::out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_data_r.blur0      <= blur0;
      out_data_r.blur1      <= blur1;
      out_data_r.blur2      <= blur2;
      out_data_r.out_col    <= s1_ocol_r;
      out_data_r.out_row    <= s1_orow_r;
      out_data_r.frame_last <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### dv/tb_gaussian_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_rgb
// Self-checking bench for the streaming 3x3 RGB blur. A line-store and window
// model in the scoreboard tracks every accepted pixel word and queues the
// blurred word it should cause. Out words are compared field by field in
// order. Covers reset geometry, clamped and mid-frame register writes,
// wide and tall frames, and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_3x3_rgb;

  localparam int LINE_DEPTH    = 2048;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TOTAL_PIXELS  = 1150;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;

  class blur_scoreboard;
    logic [11:0]       width_reg;
    logic [12:0]       height_reg;
    gb3_pkg::in_word_t line1 [LINE_DEPTH];
    gb3_pkg::in_word_t line2 [LINE_DEPTH];
    gb3_pkg::in_word_t win [2][3];
    int unsigned       col_pos;
    int unsigned       row_pos;
    gb3_pkg::out_word_t pending_blurs[$];
    int                errors;

    function new();
      width_reg  = gb3_pkg::WIDTH_RST;
      height_reg = gb3_pkg::HEIGHT_RST;
      foreach (line1[i]) begin
        line1[i] = '0;
        line2[i] = '0;
      end
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] = '0;
        end
      end
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
    endfunction

    function void set_reg(gb3_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        gb3_pkg::REG_FRAME_WIDTH: begin
          width_reg = val[11:0];
        end
        gb3_pkg::REG_FRAME_HEIGHT: begin
          height_reg = val[12:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < gb3_pkg::DIM_MIN) return gb3_pkg::DIM_MIN;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < gb3_pkg::DIM_MIN) return gb3_pkg::DIM_MIN;
      if (height_reg > gb3_pkg::HEIGHT_LIMIT) return gb3_pkg::HEIGHT_LIMIT;
      return height_reg;
    endfunction

    // pixels left until the counters are back at the frame origin
    function int unsigned to_frame_end();
      int unsigned w, h, c, r;
      w = eff_width();
      h = eff_height();
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      if (c == 0 && r == 0) return 0;
      return (h - r) * w - c;
    endfunction

    function int pending();
      return pending_blurs.size();
    endfunction

    // nb[col][row]; corners >> 4, edges >> 3, center >> 2
    function logic [7:0] blur_byte(gb3_pkg::in_word_t nb [3][3], int ch);
      int unsigned s;
      int unsigned sh;
      s = 0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          sh = (c == 1 && r == 1) ? 2 : ((c == 1 || r == 1) ? 3 : 4);
          s += 32'(nb[c][r][8*ch +: 8]) >> sh;
        end
      end
      return s[7:0];
    endfunction

    function void note_pixel(gb3_pkg::in_word_t px);
      gb3_pkg::in_word_t  nb [3][3];
      gb3_pkg::out_word_t want;
      int unsigned        w, h, c, r;
      w = eff_width();
      h = eff_height();
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      for (int i = 0; i < 3; i++) begin
        nb[0][i] = win[0][i];
        nb[1][i] = win[1][i];
      end
      nb[2][0] = line2[c];
      nb[2][1] = line1[c];
      nb[2][2] = px;
      if (c >= 2 && r >= 2) begin
        want.blur0      = blur_byte(nb, 0);
        want.blur1      = blur_byte(nb, 1);
        want.blur2      = blur_byte(nb, 2);
        want.out_col    = 11'(c - 1);
        want.out_row    = 12'(r - 1);
        want.frame_last = (c == w - 1) && (r == h - 1);
        pending_blurs.push_back(want);
      end
      for (int i = 0; i < 3; i++) begin
        win[0][i] = nb[1][i];
        win[1][i] = nb[2][i];
      end
      line2[c] = line1[c];
      line1[c] = px;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    function void cmp(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(gb3_pkg::out_word_t got);
      gb3_pkg::out_word_t want;
      if (pending_blurs.size() == 0) begin
        $error("out word %h with none pending", got);
        errors++;
        return;
      end
      want = pending_blurs.pop_front();
      cmp("blur0", want.blur0, got.blur0);
      cmp("blur1", want.blur1, got.blur1);
      cmp("blur2", want.blur2, got.blur2);
      cmp("out_col", want.out_col, got.out_col);
      cmp("out_row", want.out_row, got.out_row);
      cmp("frame_last", want.frame_last, got.frame_last);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  gb3_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  gb3_pkg::out_word_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  blur_scoreboard sb;
  bit             idle_on;
  int             sink_hold_req;
  int unsigned    pixels_sent;

  gaussian_blur_3x3_rgb dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_sink
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        wait_left = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (sink_hold_req > 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic gb3_pkg::in_word_t rand_pixel();
    gb3_pkg::in_word_t px;
    px = 24'($urandom);
    for (int ch = 0; ch < 3; ch++) begin
      if ($urandom_range(0, 9) == 0) begin
        px[8*ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    end
    return px;
  endfunction

  function automatic int unsigned pick_dim(int unsigned hi);
    case ($urandom_range(0, 9))
      0, 1: begin
        return $urandom_range(0, 2);
      end
      2: begin
        return $urandom_range(11, 20);
      end
      3: begin
        return $urandom_range(hi / 2, hi);
      end
      default: begin
        return $urandom_range(3, 10);
      end
    endcase
  endfunction

  task automatic write_reg(gb3_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // unused upper bits carry junk now and then
  task automatic set_frame(int unsigned w, int unsigned h);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
    write_reg(gb3_pkg::REG_FRAME_WIDTH, (junk & ~32'hFFF) | (w & 32'hFFF));
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
    write_reg(gb3_pkg::REG_FRAME_HEIGHT, (junk & ~32'h1FFF) | (h & 32'h1FFF));
  endtask

  task automatic send_pixel(gb3_pkg::in_word_t px);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_burst(int unsigned n);
    repeat (n) send_pixel(rand_pixel());
    end_burst();
  endtask

  // shrink to 3x3 (safe mid-frame) and run out to the frame origin, so a
  // wider frame never reads line store columns that were never written
  task automatic restart_frame();
    set_frame(gb3_pkg::DIM_MIN, gb3_pkg::DIM_MIN);
    send_burst(sb.to_frame_end());
  endtask

  initial begin : stimulus
    int unsigned       w, h, n, rest, burst_no;
    gb3_pkg::in_word_t px;
    sb            = new();
    idle_on       = 1'b0;
    sink_hold_req = 0;
    pixels_sent   = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: a run along the first line
    send_burst(200);

    restart_frame();
    for (int i = 0; i < 9; i++) send_pixel(24'hFFFFFF);
    end_burst();
    set_frame(0, 1);
    for (int i = 0; i < 9; i++) begin
      px.chan0 = i[0] ? 8'hFF : 8'h00;
      px.chan1 = i[0] ? 8'h00 : 8'hFF;
      px.chan2 = 8'(i * 31);
      send_pixel(px);
    end
    end_burst();

    // wide and tall frames, both written out of range
    set_frame(4095, 3);
    send_burst(60);
    set_frame(3, 8191);
    send_burst(60);

    burst_no = 0;
    while (pixels_sent < TOTAL_PIXELS) begin
      if (burst_no == 0) begin
        w = 8;
        h = 40;
      end else begin
        w = pick_dim(20);
        h = pick_dim(8191);
      end
      if (((w < gb3_pkg::DIM_MIN) ? int'(gb3_pkg::DIM_MIN) : w) > sb.eff_width()) begin
        restart_frame();
      end
      set_frame(w, h);
      idle_on = ($urandom_range(0, 3) != 0);
      rest    = sb.to_frame_end();
      if (rest == 0) rest = sb.eff_width() * sb.eff_height();
      if (burst_no == 0) begin
        idle_on       = 1'b0;
        sink_hold_req = LONG_HOLD;
        n             = 120;
      end else if ($urandom_range(0, 9) < 3 || rest > 300) begin
        n = $urandom_range(1, 40);
      end else begin
        n = rest;
        if ($urandom_range(0, 2) == 0 && sb.eff_width() * sb.eff_height() <= 300) begin
          n += sb.eff_width() * sb.eff_height();
        end
      end
      if (pixels_sent >= TOTAL_PIXELS) begin
        n = 0;
      end else if (n > TOTAL_PIXELS - pixels_sent) begin
        n = TOTAL_PIXELS - pixels_sent;
      end
      send_burst(n);
      burst_no++;
    end

    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
